>>> src/mbg_pkg.sv
// shared constants, types and helpers of the maze backtracker generator
package mbg_pkg;

   localparam int GRID_COLS   = 63;
   localparam int GRID_ROWS   = 31;
   localparam int STACK_DEPTH = 512;

   localparam int GRID_CELLS = GRID_COLS * GRID_ROWS;
   localparam int X_W        = $clog2(GRID_COLS);
   localparam int Y_W        = $clog2(GRID_ROWS);
   localparam int ADDR_W     = $clog2(GRID_CELLS);
   localparam int S_W        = $clog2(STACK_DEPTH);
   localparam int SP_W       = $clog2(STACK_DEPTH + 1);

   typedef enum logic [1:0] {
      OP_RESTART = 2'd0,
      OP_RANDOM  = 2'd1,
      OP_READ    = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      DIR_NORTH = 2'd0,
      DIR_EAST  = 2'd1,
      DIR_SOUTH = 2'd2,
      DIR_WEST  = 2'd3
   } dir_type;

   typedef enum logic {
      CSR_START_X = 1'b0,
      CSR_START_Y = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [X_W-1:0]  x;
      logic [Y_W-1:0]  y;
      logic [3:0][1:0] dirs;
      logic [3:0]      step;
   } frame_type;

   typedef struct packed {
      logic              rd_en;
      logic              wr_en;
      logic [ADDR_W-1:0] addr;
      logic              wdata;
   } grid_req_type;

   function automatic logic [ADDR_W-1:0] cell_addr(logic [X_W-1:0] x, logic [Y_W-1:0] y);
      logic [2*ADDR_W-1:0] prod;
      prod = (2*ADDR_W)'(y) * (2*ADDR_W)'(GRID_COLS);
      return prod[ADDR_W-1:0] + ADDR_W'(x);
   endfunction

endpackage

>>> src/mbg_grid.sv
// wall/passage grid memory with registered read
module mbg_grid (
   input  logic                 clock,
   input  mbg_pkg::grid_req_type grid_req,
   output logic                 grid_rdata
);

   logic grid_mem [mbg_pkg::GRID_CELLS];
   logic grid_rdata_ff;

   always_ff @(posedge clock) begin
      if (grid_req.wr_en) begin
         grid_mem[grid_req.addr] <= grid_req.wdata;
      end
      if (grid_req.rd_en) begin
         grid_rdata_ff <= grid_mem[grid_req.addr];
      end
   end

   assign grid_rdata = grid_rdata_ff;

endmodule

>>> src/maze_backtracker_generator.sv
// read: ST_READ then ST_DONE fill the result register; restart: wall sweep (ST_CLEAR), ST_START, ST_DONE
// random item: one shuffle swap; the fourth swap moves on to ST_ADV, which tries directions via ST_PROBE
// (ST_CARVE, ST_PUSH on a wall) and pops frames via ST_POPW, all bound by the registered grid and stack reads
// one transaction in flight; the next is taken once the result register is free or being taken
// after reset the grid is swept to walls with req_tready low;
// csr writes are taken at any time
module maze_backtracker_generator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // rand_bits[1:0], cell_x[7:2], cell_y[12:8], zero[15:13]
   input  logic [1:0]  req_tuser,  // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // cell_value[0], needs_random[1], done_res[2], zero[7:3]
   input  logic        csr_we,
   input  logic [0:0]  csr_addr,
   input  logic [5:0]  csr_wdata
);

   typedef enum logic [9:0] {
      ST_CLEAR = 10'b00_0000_0001,
      ST_START = 10'b00_0000_0010,
      ST_IDLE  = 10'b00_0000_0100,
      ST_READ  = 10'b00_0000_1000,
      ST_ADV   = 10'b00_0001_0000,
      ST_PROBE = 10'b00_0010_0000,
      ST_CARVE = 10'b00_0100_0000,
      ST_PUSH  = 10'b00_1000_0000,
      ST_POPW  = 10'b01_0000_0000,
      ST_DONE  = 10'b10_0000_0000
   } state_type;

   state_type                   state_ff, state_in;
   logic [mbg_pkg::SP_W-1:0]    sp_ff, sp_in;
   logic                        gen_ff, gen_in;
   logic                        restart_ff, restart_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [2:0]                  rsp_data_ff, rsp_data_in;
   logic [5:0]                  start_x_ff;
   logic [4:0]                  start_y_ff;
   logic [mbg_pkg::ADDR_W-1:0]  clr_cnt_ff, clr_cnt_in;
   mbg_pkg::frame_type          top_ff, top_in;
   logic                        cell_ff, cell_in;
   logic [mbg_pkg::X_W-1:0]     nx_ff, nx_in, mx_ff, mx_in;
   logic [mbg_pkg::Y_W-1:0]     ny_ff, ny_in, my_ff, my_in;

   mbg_pkg::frame_type          stk_mem [mbg_pkg::STACK_DEPTH];
   mbg_pkg::frame_type          stk_rdata_ff;
   logic                        stk_wr_en, stk_rd_en;
   logic [mbg_pkg::S_W-1:0]     stk_wr_idx, stk_rd_idx;

   mbg_pkg::grid_req_type       grid_req;
   logic                        grid_rdata;

   mbg_pkg::op_type             req_op;
   logic [1:0]                  req_rb;
   logic [5:0]                  req_x;
   logic [4:0]                  req_y;
   logic                        accept;

   logic [mbg_pkg::SP_W-1:0]    sp_m1, sp_m2;
   logic [mbg_pkg::X_W:0]       x_ext;
   logic [mbg_pkg::Y_W:0]       y_ext;
   mbg_pkg::dir_type            cur_dir;
   logic [1:0]                  tmp_dir;

   assign req_op  = mbg_pkg::op_type'(req_tuser);
   assign req_rb  = req_tdata[1:0];
   assign req_x   = req_tdata[7:2];
   assign req_y   = req_tdata[12:8];
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept  = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_data_ff};

   assign sp_m1 = sp_ff - mbg_pkg::SP_W'(1);
   assign sp_m2 = sp_ff - mbg_pkg::SP_W'(2);
   assign x_ext = {1'b0, top_ff.x};
   assign y_ext = {1'b0, top_ff.y};
   assign cur_dir = mbg_pkg::dir_type'(top_ff.dirs[top_ff.step[1:0]]);

   mbg_grid u_grid (
      .clock      (clock),
      .grid_req   (grid_req),
      .grid_rdata (grid_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      sp_in        = sp_ff;
      gen_in       = gen_ff;
      restart_in   = restart_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      clr_cnt_in   = clr_cnt_ff;
      top_in       = top_ff;
      cell_in      = cell_ff;
      nx_in        = nx_ff;
      ny_in        = ny_ff;
      mx_in        = mx_ff;
      my_in        = my_ff;
      tmp_dir      = 2'd0;
      grid_req     = '0;
      stk_wr_en    = 1'b0;
      stk_rd_en    = 1'b0;
      stk_wr_idx   = sp_m1[mbg_pkg::S_W-1:0];
      stk_rd_idx   = sp_m2[mbg_pkg::S_W-1:0];

      case (state_ff)
         ST_CLEAR: begin
            grid_req.wr_en = 1'b1;
            grid_req.addr  = clr_cnt_ff;
            grid_req.wdata = 1'b1;
            clr_cnt_in     = clr_cnt_ff + mbg_pkg::ADDR_W'(1);
            if (clr_cnt_ff == mbg_pkg::ADDR_W'(mbg_pkg::GRID_CELLS - 1)) begin
               state_in = restart_ff ? ST_START : ST_IDLE;
            end
         end
         ST_START: begin
            if (32'(start_x_ff) < mbg_pkg::GRID_COLS && 32'(start_y_ff) < mbg_pkg::GRID_ROWS) begin
               top_in.x    = mbg_pkg::X_W'(start_x_ff);
               top_in.y    = mbg_pkg::Y_W'(start_y_ff);
               top_in.dirs = {mbg_pkg::DIR_WEST, mbg_pkg::DIR_SOUTH,
                              mbg_pkg::DIR_EAST, mbg_pkg::DIR_NORTH};
               top_in.step = 4'd0;
               grid_req.wr_en = 1'b1;
               grid_req.addr  = mbg_pkg::cell_addr(top_in.x, top_in.y);
               grid_req.wdata = 1'b0;
               sp_in = mbg_pkg::SP_W'(1);
            end
            state_in = ST_DONE;
         end
         ST_IDLE: begin
            if (accept) begin
               cell_in  = 1'b0;
               state_in = ST_DONE;
               case (req_op)
                  mbg_pkg::OP_RESTART: begin
                     gen_in     = 1'b1;
                     sp_in      = '0;
                     restart_in = 1'b1;
                     clr_cnt_in = '0;
                     state_in   = ST_CLEAR;
                  end
                  mbg_pkg::OP_RANDOM: begin
                     if (gen_ff && sp_ff != '0 && top_ff.step < 4'd4) begin
                        // one swap of the top frame's shuffle
                        tmp_dir = top_ff.dirs[req_rb];
                        top_in.dirs[req_rb] = top_ff.dirs[top_ff.step[1:0]];
                        top_in.dirs[top_ff.step[1:0]] = tmp_dir;
                        top_in.step = top_ff.step + 4'd1;
                        if (top_ff.step == 4'd3) begin
                           state_in = ST_ADV;
                        end
                     end
                  end
                  mbg_pkg::OP_READ: begin
                     if (32'(req_x) < mbg_pkg::GRID_COLS && 32'(req_y) < mbg_pkg::GRID_ROWS) begin
                        grid_req.rd_en = 1'b1;
                        grid_req.addr  = mbg_pkg::cell_addr(mbg_pkg::X_W'(req_x),
                                                            mbg_pkg::Y_W'(req_y));
                        state_in = ST_READ;
                     end else begin
                        cell_in = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            cell_in  = grid_rdata;
            state_in = ST_DONE;
         end
         ST_ADV: begin
            if (sp_ff == '0 || top_ff.step < 4'd4) begin
               state_in = ST_DONE;
            end else if (top_ff.step >= 4'd8) begin
               // frame exhausted: pop and fetch the parent
               sp_in = sp_m1;
               if (sp_m1 != '0) begin
                  stk_rd_en = 1'b1;
                  state_in  = ST_POPW;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               top_in.step = top_ff.step + 4'd1;
               nx_in = top_ff.x;
               ny_in = top_ff.y;
               mx_in = top_ff.x;
               my_in = top_ff.y;
               case (cur_dir)
                  mbg_pkg::DIR_NORTH: begin
                     ny_in = top_ff.y - mbg_pkg::Y_W'(2);
                     my_in = top_ff.y - mbg_pkg::Y_W'(1);
                     if (top_ff.y >= mbg_pkg::Y_W'(2)) state_in = ST_PROBE;
                  end
                  mbg_pkg::DIR_EAST: begin
                     nx_in = top_ff.x + mbg_pkg::X_W'(2);
                     mx_in = top_ff.x + mbg_pkg::X_W'(1);
                     if (32'(x_ext + (mbg_pkg::X_W+1)'(2)) < mbg_pkg::GRID_COLS) begin
                        state_in = ST_PROBE;
                     end
                  end
                  mbg_pkg::DIR_SOUTH: begin
                     ny_in = top_ff.y + mbg_pkg::Y_W'(2);
                     my_in = top_ff.y + mbg_pkg::Y_W'(1);
                     if (32'(y_ext + (mbg_pkg::Y_W+1)'(2)) < mbg_pkg::GRID_ROWS) begin
                        state_in = ST_PROBE;
                     end
                  end
                  default: begin
                     nx_in = top_ff.x - mbg_pkg::X_W'(2);
                     mx_in = top_ff.x - mbg_pkg::X_W'(1);
                     if (top_ff.x >= mbg_pkg::X_W'(2)) state_in = ST_PROBE;
                  end
               endcase
               if (state_in == ST_PROBE) begin
                  grid_req.rd_en = 1'b1;
                  grid_req.addr  = mbg_pkg::cell_addr(nx_in, ny_in);
               end
            end
         end
         ST_PROBE: begin
            if (grid_rdata && sp_ff < mbg_pkg::SP_W'(mbg_pkg::STACK_DEPTH)) begin
               state_in = ST_CARVE;
            end else begin
               state_in = ST_ADV;
            end
         end
         ST_CARVE: begin
            grid_req.wr_en = 1'b1;
            grid_req.addr  = mbg_pkg::cell_addr(mx_ff, my_ff);
            grid_req.wdata = 1'b0;
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            grid_req.wr_en = 1'b1;
            grid_req.addr  = mbg_pkg::cell_addr(nx_ff, ny_ff);
            grid_req.wdata = 1'b0;
            // spill the current top, new frame becomes the top
            stk_wr_en   = 1'b1;
            top_in.x    = nx_ff;
            top_in.y    = ny_ff;
            top_in.dirs = {mbg_pkg::DIR_WEST, mbg_pkg::DIR_SOUTH,
                           mbg_pkg::DIR_EAST, mbg_pkg::DIR_NORTH};
            top_in.step = 4'd0;
            sp_in    = sp_ff + mbg_pkg::SP_W'(1);
            state_in = ST_DONE;
         end
         ST_POPW: begin
            top_in   = stk_rdata_ff;
            state_in = ST_ADV;
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = {gen_ff && sp_ff == '0, gen_ff && sp_ff != '0, cell_ff};
            restart_in   = 1'b0;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (stk_wr_en) begin
         stk_mem[stk_wr_idx] <= top_ff;
      end
      if (stk_rd_en) begin
         stk_rdata_ff <= stk_mem[stk_rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      top_ff      <= top_in;
      cell_ff     <= cell_in;
      nx_ff       <= nx_in;
      ny_ff       <= ny_in;
      mx_ff       <= mx_in;
      my_ff       <= my_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sp_ff        <= '0;
         gen_ff       <= 1'b0;
         restart_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         clr_cnt_ff   <= '0;
         start_x_ff   <= 6'd1;
         start_y_ff   <= 5'd1;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         gen_ff       <= gen_in;
         restart_ff   <= restart_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_cnt_ff   <= clr_cnt_in;
         if (csr_we) begin
            case (mbg_pkg::csr_index_type'(csr_addr))
               mbg_pkg::CSR_START_X: start_x_ff <= csr_wdata;
               mbg_pkg::CSR_START_Y: start_y_ff <= csr_wdata[4:0];
               default: begin
               end
            endcase
         end
      end
   end

endmodule

>>> sim/maze_backtracker_generator_tb.sv
// testbench for the maze backtracker generator: directed table, start outside the grid, then random carving sessions
`timescale 1ns / 1ps

module maze_backtracker_generator_tb;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic        csr_we;
   logic [0:0]  csr_addr;
   logic [5:0]  csr_wdata;

   maze_backtracker_generator dut (.*);

   typedef struct packed {
      logic cell_value;
      logic needs_random;
      logic done_res;
   } status_type;

   typedef struct {
      mbg_pkg::op_type op;
      logic [1:0]      rbits;
      logic [5:0]      cx;
      logic [4:0]      cy;
      logic            known;
      status_type      want;
   } cmd_type;

   // maze model state
   logic             maze_wall [mbg_pkg::GRID_ROWS][mbg_pkg::GRID_COLS];
   logic [7:0]       fx [mbg_pkg::STACK_DEPTH];
   logic [7:0]       fy [mbg_pkg::STACK_DEPTH];
   mbg_pkg::dir_type fdir [mbg_pkg::STACK_DEPTH][4];
   int               fstep [mbg_pkg::STACK_DEPTH];
   int               depth_cnt;
   logic             session_on;
   int               cfg_x, cfg_y;

   status_type status_fifo [$];
   int         err_cnt;
   int         rsp_cnt;
   int         sessions_done;
   logic       long_hold;

   always #10 clock = ~clock;

   task automatic report(input string what, input status_type got, input status_type want);
      err_cnt++;
      $display("mismatch %s: got %b want %b (rsp %0d)", what, got, want, rsp_cnt);
   endtask

   function automatic void model_push(input int x, input int y);
      fx[depth_cnt] = x[7:0];
      fy[depth_cnt] = y[7:0];
      fdir[depth_cnt][0] = mbg_pkg::DIR_NORTH;
      fdir[depth_cnt][1] = mbg_pkg::DIR_EAST;
      fdir[depth_cnt][2] = mbg_pkg::DIR_SOUTH;
      fdir[depth_cnt][3] = mbg_pkg::DIR_WEST;
      fstep[depth_cnt] = 0;
      maze_wall[y][x] = 1'b0;
      depth_cnt++;
   endfunction

   function automatic void model_carve();
      int t, dx, dy, x2, y2;
      while (depth_cnt > 0) begin
         t = depth_cnt - 1;
         if (fstep[t] < 4) return;
         if (fstep[t] >= 8) begin
            depth_cnt--;
            continue;
         end
         dx = 0;
         dy = 0;
         case (fdir[t][(fstep[t] - 4) & 3])
            mbg_pkg::DIR_NORTH: dy = -1;
            mbg_pkg::DIR_EAST:  dx = 1;
            mbg_pkg::DIR_SOUTH: dy = 1;
            default:            dx = -1;
         endcase
         fstep[t]++;
         x2 = int'(fx[t]) + 2 * dx;
         y2 = int'(fy[t]) + 2 * dy;
         if (x2 < 0 || x2 >= mbg_pkg::GRID_COLS || y2 < 0 || y2 >= mbg_pkg::GRID_ROWS) continue;
         if (!maze_wall[y2][x2]) continue;
         if (depth_cnt >= mbg_pkg::STACK_DEPTH) continue;
         maze_wall[y2 - dy][x2 - dx] = 1'b0;
         model_push(x2, y2);
         return;
      end
   endfunction

   function automatic status_type model_apply(input cmd_type c);
      status_type s;
      int t, i;
      mbg_pkg::dir_type d;
      s = '0;
      case (c.op)
         mbg_pkg::OP_RESTART: begin
            foreach (maze_wall[r, k]) maze_wall[r][k] = 1'b1;
            depth_cnt = 0;
            session_on = 1'b1;
            if (cfg_x < mbg_pkg::GRID_COLS && cfg_y < mbg_pkg::GRID_ROWS) begin
               model_push(cfg_x, cfg_y);
            end
         end
         mbg_pkg::OP_RANDOM: begin
            if (session_on && depth_cnt > 0) begin
               t = depth_cnt - 1;
               if (fstep[t] < 4) begin
                  i = fstep[t];
                  d = fdir[t][c.rbits];
                  fdir[t][c.rbits] = fdir[t][i];
                  fdir[t][i] = d;
                  fstep[t]++;
                  model_carve();
                  if (session_on && depth_cnt == 0) sessions_done++;
               end
            end
         end
         mbg_pkg::OP_READ: begin
            if (c.cx < mbg_pkg::GRID_COLS && c.cy < mbg_pkg::GRID_ROWS) begin
               s.cell_value = maze_wall[c.cy][c.cx];
            end else begin
               s.cell_value = 1'b1;
            end
         end
         default: ;
      endcase
      s.needs_random = session_on && depth_cnt > 0;
      s.done_res = session_on && depth_cnt == 0;
      return s;
   endfunction

   // sender: bursts with random gaps; each accepted transaction is predicted
   task automatic send(input cmd_type c);
      status_type s;
      if ($urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c.op;
      req_tdata  <= {3'b000, c.cy, c.cx, c.rbits};
      do @(posedge clock); while (!req_tready);
      s = model_apply(c);
      if (c.known && s != c.want) report("directed table", s, c.want);
      status_fifo.push_back(s);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (status_fifo.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input mbg_pkg::csr_index_type idx, input int v);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= v[5:0];
      @(posedge clock);
      csr_we    <= 1'b0;
      @(posedge clock);
      if (idx == mbg_pkg::CSR_START_X) cfg_x = v & 63;
      else cfg_y = v & 31;
   endtask

   function automatic cmd_type mk(input mbg_pkg::op_type op, input int rb, input int x,
                                  input int y);
      cmd_type c;
      c.op = op;
      c.rbits = rb[1:0];
      c.cx = x[5:0];
      c.cy = y[4:0];
      c.known = 1'b0;
      c.want = '0;
      return c;
   endfunction

   function automatic cmd_type mkk(input mbg_pkg::op_type op, input int rb, input int x,
                                   input int y, input status_type w);
      cmd_type c;
      c = mk(op, rb, x, y);
      c.known = 1'b1;
      c.want = w;
      return c;
   endfunction

   // receiver: own stall pattern plus one long hold-off
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= !long_hold && ($urandom_range(0, 7) > 1 || rsp_cnt[6]);
   end

   always @(posedge clock) begin
      status_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.cell_value   = rsp_tdata[0];
         got.needs_random = rsp_tdata[1];
         got.done_res     = rsp_tdata[2];
         want = '0;
         if (status_fifo.size() == 0) begin
            report("unexpected transaction", got, '0);
         end else begin
            want = status_fifo.pop_front();
            if (got.cell_value != want.cell_value) report("cell_value", got, want);
            if (got.needs_random != want.needs_random) report("needs_random", got, want);
            if (got.done_res != want.done_res) report("done_res", got, want);
         end
         if (rsp_tdata[7:3] != 0) report("pad bits", got, want);
         rsp_cnt++;
      end
   end

   // long receiver hold-off while the sender keeps offering
   initial begin
      long_hold = 1'b0;
      wait (rsp_cnt > 300);
      long_hold = 1'b1;
      repeat (300) @(posedge clock);
      long_hold = 1'b0;
   end

   initial begin
      #100ms;
      $display("FAIL maze_backtracker_generator");
      $finish;
   end

   initial begin
      cmd_type table_rows [$];
      cmd_type c;
      int n, k;
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = mbg_pkg::OP_RESTART;
      csr_we = 1'b0;
      csr_addr = mbg_pkg::CSR_START_X;
      csr_wdata = '0;
      err_cnt = 0;
      rsp_cnt = 0;
      sessions_done = 0;
      depth_cnt = 0;
      session_on = 1'b0;
      cfg_x = 1;
      cfg_y = 1;
      foreach (maze_wall[r, q]) maze_wall[r][q] = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed rows: idle status, extremes, outside reads, ignored ops
      table_rows.push_back(mkk(mbg_pkg::OP_READ, 3, 0, 0, 3'b100));
      table_rows.push_back(mkk(mbg_pkg::OP_READ, 0, 63, 31, 3'b100));
      table_rows.push_back(mkk(mbg_pkg::OP_RANDOM, 3, 0, 0, 3'b000));
      table_rows.push_back(mkk(mbg_pkg::OP_NONE, 3, 63, 31, 3'b000));
      table_rows.push_back(mkk(mbg_pkg::OP_RESTART, 0, 0, 0, 3'b010));
      table_rows.push_back(mkk(mbg_pkg::OP_READ, 0, 1, 1, 3'b010));
      table_rows.push_back(mkk(mbg_pkg::OP_READ, 0, 62, 30, 3'b110));
      table_rows.push_back(mkk(mbg_pkg::OP_READ, 0, 62, 31, 3'b110));
      table_rows.push_back(mkk(mbg_pkg::OP_NONE, 0, 1, 1, 3'b010));
      for (int i = 0; i < 12; i++) table_rows.push_back(mk(mbg_pkg::OP_RANDOM, i & 3, 0, 0));
      table_rows.push_back(mk(mbg_pkg::OP_READ, 0, 2, 1));
      table_rows.push_back(mk(mbg_pkg::OP_READ, 0, 1, 2));
      foreach (table_rows[i]) send(table_rows[i]);
      drain();

      // start outside the grid finishes at once
      write_csr(mbg_pkg::CSR_START_X, 63);
      write_csr(mbg_pkg::CSR_START_Y, 31);
      send(mkk(mbg_pkg::OP_RESTART, 0, 0, 0, 3'b001));
      send(mkk(mbg_pkg::OP_RANDOM, 1, 0, 0, 3'b001));
      send(mkk(mbg_pkg::OP_READ, 0, 1, 1, 3'b101));
      drain();

      // random sessions, start cells cycling through corners and random spots
      n = 0;
      k = 0;
      while (n < 1200) begin
         drain();
         case (k % 4)
            0: begin
               write_csr(mbg_pkg::CSR_START_X, 0);
               write_csr(mbg_pkg::CSR_START_Y, 0);
            end
            1: begin
               write_csr(mbg_pkg::CSR_START_X, 62);
               write_csr(mbg_pkg::CSR_START_Y, 30);
            end
            default: begin
               write_csr(mbg_pkg::CSR_START_X, $urandom_range(0, 63));
               write_csr(mbg_pkg::CSR_START_Y, $urandom_range(0, 31));
            end
         endcase
         k++;
         send(mk(mbg_pkg::OP_RESTART, $urandom, $urandom, $urandom));
         n++;
         for (int j = 0; j < 400 && depth_cnt > 0; j++) begin
            case ($urandom_range(0, 19))
               0, 1: c = mk(mbg_pkg::OP_READ, $urandom, $urandom_range(0, 63),
                            $urandom_range(0, 31));
               2:    c = mk(mbg_pkg::OP_NONE, $urandom, $urandom, $urandom);
               default: c = mk(mbg_pkg::OP_RANDOM, $urandom, $urandom, $urandom);
            endcase
            send(c);
            n++;
         end
         for (int j = 0; j < 20; j++) begin
            send(mk(mbg_pkg::OP_READ, $urandom, $urandom_range(0, 62), $urandom_range(0, 30)));
            n++;
         end
      end
      drain();
      repeat (200) @(posedge clock);
      if (status_fifo.size() != 0) begin
         err_cnt++;
         $display("%0d results never arrived", status_fifo.size());
      end
      $display("covered %0d transactions over %0d restarts, %0d mazes carved to completion",
               rsp_cnt, k + 2, sessions_done);
      if (err_cnt == 0) begin
         $display("PASS maze_backtracker_generator");
      end else begin
         $display("FAIL maze_backtracker_generator");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/mbg_pkg.sv
src/mbg_grid.sv
src/maze_backtracker_generator.sv
sim/maze_backtracker_generator_tb.sv
